// File: design/joint_command_safety_supervisor_top_macros.svh
// Assertion macros for the joint command safety supervisor.
// Included by the top level; expects clk and rst_n in scope.
`ifndef JOINT_COMMAND_SAFETY_SUPERVISOR_TOP_MACROS_SVH
`define JOINT_COMMAND_SAFETY_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define JCSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define JCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/jcss_pkg.sv
// Shared types, codes and constants of the joint command safety supervisor.
// No dependencies; imported by every module of the block.
package jcss_pkg;

    localparam int JOINT_W = 5;
    localparam int RAMP_W  = 16;
    localparam int POSE_W  = 16;
    localparam int NUM_FIELDS = 5;

    localparam logic [RAMP_W-1:0] RAMP_TICKS_RST = 16'd300;
    localparam logic [RAMP_W-1:0] ELAPSED_MAX    = 16'hFFFF;

    // Item kinds
    localparam logic [1:0] FN_JOY  = 2'd0;
    localparam logic [1:0] FN_MEAS = 2'd1;
    localparam logic [1:0] FN_CMD  = 2'd2;
    localparam logic [1:0] FN_TICK = 2'd3;

    // Configuration register indexes
    localparam logic CFG_START_IN_CONTROL = 1'b0;
    localparam logic CFG_RAMP_TICKS       = 1'b1;

    // Result kinds
    localparam logic KIND_JOINT  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Field slots of one joint row in the table memory
    localparam int F_MEAS   = 0;
    localparam int F_RSTART = 1;
    localparam int F_TPOS   = 2;
    localparam int F_TVEL   = 3;
    localparam int F_TEFF   = 4;

    typedef logic [NUM_FIELDS-1:0] fmask_t;

    localparam fmask_t M_MEAS   = 5'b00001;
    localparam fmask_t M_RSTART = 5'b00010;
    localparam fmask_t M_TPOS   = 5'b00100;
    localparam fmask_t M_TVEL   = 5'b01000;
    localparam fmask_t M_TEFF   = 5'b10000;

    typedef enum logic [1:0] {
        MODE_NEUTRAL = 2'd0,
        MODE_CONTROL = 2'd1,
        MODE_DAMP    = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_ELEM,
        ST_REPORT,
        ST_TICK_RD,
        ST_TICK_SEL,
        ST_TICK_SUM,
        ST_TICK_DIV,
        ST_TICK_EMIT
    } st_t;

    typedef struct packed {
        logic   we;
        fmask_t wmask;
    } mem_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Default pose in Q3.12; joints without an entry sit at zero
    function automatic logic signed [POSE_W-1:0] jcss_pose(input logic [5:0] j);
        logic signed [POSE_W-1:0] p;
        case (j)
            6'd0:    p = -16'sd410;
            6'd3:    p = 16'sd1229;
            6'd4:    p = -16'sd819;
            6'd6:    p = -16'sd410;
            6'd9:    p = 16'sd1229;
            6'd10:   p = -16'sd819;
            6'd15:   p = 16'sd1516;
            6'd16:   p = 16'sd2540;
            6'd18:   p = 16'sd3359;
            6'd22:   p = 16'sd1352;
            6'd23:   p = -16'sd2744;
            6'd25:   p = 16'sd4137;
            default: p = 16'sd0;
        endcase
        return p;
    endfunction

endpackage

// File: design/joint_command_safety_supervisor_top.sv
// Top level of the joint command safety supervisor: sequencer, scalar state,
// output register. Depends on jcss_pkg, jcss_mem, jcss_div and the macro header.
`include "joint_command_safety_supervisor_top_macros.svh"

// One item is taken at a time; in_stall stays high until its work is done.
// Joystick and measured items pass through the execute state, a command element
// also through the element state, and a mode report adds the report state. The
// first measured message, the opening of each command message and the start of a
// ramp out of control add a copy pass over the joint table, a read and a write
// per joint, set by the single read and write port of the table memory. A
// publish tick reads, selects and emits each joint in turn in damp, control or
// at rest in neutral; during the neutral ramp each joint also passes through the
// restoring divider. Results wait in a one-entry output register, so a stalled
// output holds up only the next result.
// Configuration writes are taken at any time and belong only to idle periods.
module joint_command_safety_supervisor_top #(
    parameter int NUM_JOINTS  = 29,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [jcss_pkg::JOINT_W-1:0] joint,
    input  logic signed [VALUE_WIDTH-1:0] position,
    input  logic signed [VALUE_WIDTH-1:0] velocity,
    input  logic signed [VALUE_WIDTH-1:0] effort,
    input  logic                         with_position,
    input  logic                         with_velocity,
    input  logic                         with_effort,
    input  logic                         last,
    input  logic                         damp_button,
    input  logic                         control_button,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [jcss_pkg::JOINT_W-1:0] out_joint,
    output logic signed [VALUE_WIDTH-1:0] out_position,
    output logic signed [VALUE_WIDTH-1:0] out_velocity,
    output logic signed [VALUE_WIDTH-1:0] out_effort,
    output logic [1:0]                   mode,
    output logic                         end_of_run,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [jcss_pkg::RAMP_W-1:0]  cfg_data
);
    import jcss_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int AW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int PW  = VW + 18;
    localparam int SW  = VW + 20;
    localparam int DW  = VW + 17;
    localparam int VSW = RAMP_W + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_JOINTS - 1);

    // Sequencer and scalar state
    st_t             state_reg, state_next;
    st_t             after_reg, after_next;
    logic [AW-1:0]   idx_reg, idx_next;
    fmask_t          sweep_mask_reg, sweep_mask_next;
    mode_t           mode_reg, mode_next;
    logic [RAMP_W-1:0] elapsed_reg, elapsed_next;
    logic            ramp_active_reg, ramp_active_next;
    logic            seen_meas_reg, seen_meas_next;
    logic            seen_cmd_reg, seen_cmd_next;
    logic            prev_ctrl_reg, prev_ctrl_next;
    logic            cmd_open_reg, cmd_open_next;
    logic            start_ctrl_reg, start_ctrl_next;
    logic [RAMP_W-1:0] ramp_ticks_reg, ramp_ticks_next;

    // Latched request
    logic [1:0]          func_reg;
    logic [JOINT_W-1:0]  joint_reg;
    logic [VW-1:0]       pos_reg, vel_reg, eff_reg;
    logic                hp_reg, hv_reg, he_reg, last_reg, damp_reg, ctrl_reg;

    // Per-joint result staging and ramp products
    logic [VW-1:0]       res_pos_reg, res_pos_next;
    logic [VW-1:0]       res_vel_reg, res_vel_next;
    logic [VW-1:0]       res_eff_reg, res_eff_next;
    logic signed [PW-1:0] p1_reg, p1_next;
    logic signed [PW-1:0] p2_reg, p2_next;

    // Output register
    logic                out_valid_reg;
    logic                kind_reg;
    logic [JOINT_W-1:0]  ojoint_reg;
    logic [VW-1:0]       opos_reg, ovel_reg, oeff_reg;
    logic [1:0]          omode_reg;
    logic                eor_reg;

    // Load request into the output register
    logic                out_load;
    logic                ld_kind;
    logic [JOINT_W-1:0]  ld_joint;
    logic [VW-1:0]       ld_pos, ld_vel, ld_eff;
    logic                ld_eor;
    logic                out_free;

    // Memory and divider connections
    mem_ctl_t            mctl;
    logic [AW-1:0]       waddr;
    logic [NUM_FIELDS-1:0][VW-1:0] wdata;
    logic [NUM_FIELDS-1:0][VW-1:0] rdata;
    logic                div_start;
    div_stat_t           div_stat;
    logic [VW-1:0]       div_q;
    logic [DW-1:0]       dividend;
    logic [VSW-1:0]      divisor;

    // Helpers
    logic                in_accept;
    logic                jvalid;
    logic                ctrl_edge;
    logic [RAMP_W-1:0]   e_inc;
    logic [RAMP_W:0]     t_minus_e;
    logic signed [VW-1:0] pose_v;
    logic [SW-1:0]       sum_w;
    logic [SW-1:0]       nb_w;
    fmask_t              elem_mask;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign jvalid    = (7'(joint_reg) < 7'(NUM_JOINTS));
    assign ctrl_edge = ctrl_reg && !prev_ctrl_reg;
    assign e_inc     = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign t_minus_e = {1'b0, ramp_ticks_reg} - {1'b0, elapsed_reg};
    assign pose_v    = VW'(jcss_pose(6'(idx_reg)));
    assign elem_mask = (hp_reg ? M_TPOS : '0) | (hv_reg ? M_TVEL : '0)
                     | (he_reg ? M_TEFF : '0);

    // Biased numerator: 2*num + T + 2^VW*T, so the quotient is unsigned
    assign sum_w    = SW'(p1_reg) + SW'(p2_reg);
    assign nb_w     = {sum_w[SW-2:0], 1'b0} + SW'(ramp_ticks_reg)
                    + (SW'(ramp_ticks_reg) << VW);
    assign dividend = nb_w[DW-1:0];
    assign divisor  = {ramp_ticks_reg, 1'b0};

    jcss_mem #(
        .VW (VW),
        .N  (NUM_JOINTS),
        .AW (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    jcss_div #(
        .VW  (VW),
        .DW  (DW),
        .VSW (VSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Next state, table accesses and result loads
    always_comb
    begin
        state_next       = state_reg;
        after_next       = after_reg;
        idx_next         = idx_reg;
        sweep_mask_next  = sweep_mask_reg;
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        ramp_active_next = ramp_active_reg;
        seen_meas_next   = seen_meas_reg;
        seen_cmd_next    = seen_cmd_reg;
        prev_ctrl_next   = prev_ctrl_reg;
        cmd_open_next    = cmd_open_reg;
        start_ctrl_next  = start_ctrl_reg;
        ramp_ticks_next  = ramp_ticks_reg;
        res_pos_next     = res_pos_reg;
        res_vel_next     = res_vel_reg;
        res_eff_next     = res_eff_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        mctl             = '0;
        waddr            = idx_reg;
        wdata            = '0;
        out_load         = 1'b0;
        ld_kind          = KIND_JOINT;
        ld_joint         = '0;
        ld_pos           = '0;
        ld_vel           = '0;
        ld_eff           = '0;
        ld_eor           = 1'b0;
        div_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
                case (func_reg)
                    FN_JOY:
                    begin
                        if (damp_reg && mode_reg != MODE_DAMP)
                        begin
                            ramp_active_next = 1'b0;
                            mode_next        = MODE_DAMP;
                            state_next       = ST_REPORT;
                        end
                        else if (mode_reg != MODE_DAMP)
                        begin
                            prev_ctrl_next = ctrl_reg;
                            if (ctrl_edge && mode_reg == MODE_CONTROL)
                            begin
                                mode_next = MODE_NEUTRAL;
                                if (seen_meas_reg)
                                begin
                                    elapsed_next     = '0;
                                    ramp_active_next = 1'b1;
                                    sweep_mask_next  = M_RSTART;
                                    after_next       = ST_REPORT;
                                    state_next       = ST_SWEEP_RD;
                                end
                                else
                                begin
                                    state_next = ST_REPORT;
                                end
                            end
                            else if (ctrl_edge && !ramp_active_reg && seen_cmd_reg)
                            begin
                                mode_next  = MODE_CONTROL;
                                state_next = ST_REPORT;
                            end
                        end
                    end
                    FN_MEAS:
                    begin
                        waddr          = AW'(joint_reg);
                        mctl.we        = jvalid;
                        mctl.wmask     = M_MEAS;
                        wdata[F_MEAS]  = pos_reg;
                        if (last_reg && !seen_meas_reg)
                        begin
                            seen_meas_next  = 1'b1;
                            sweep_mask_next = M_TPOS | M_TVEL | M_TEFF;
                            after_next      = ST_IDLE;
                            state_next      = ST_SWEEP_RD;
                            if (mode_reg == MODE_NEUTRAL)
                            begin
                                sweep_mask_next  = M_TPOS | M_TVEL | M_TEFF | M_RSTART;
                                elapsed_next     = '0;
                                ramp_active_next = 1'b1;
                            end
                        end
                    end
                    FN_CMD:
                    begin
                        if (seen_meas_reg && !cmd_open_reg)
                        begin
                            cmd_open_next   = 1'b1;
                            sweep_mask_next = M_TVEL | M_TEFF | (seen_cmd_reg ? '0 : M_TPOS);
                            after_next      = ST_ELEM;
                            state_next      = ST_SWEEP_RD;
                        end
                        else if (seen_meas_reg)
                        begin
                            state_next = ST_ELEM;
                        end
                    end
                    FN_TICK:
                    begin
                        if (seen_meas_reg)
                        begin
                            if (mode_reg == MODE_NEUTRAL && ramp_active_reg)
                            begin
                                elapsed_next = e_inc;
                                if (e_inc >= ramp_ticks_reg)
                                begin
                                    ramp_active_next = 1'b0;
                                end
                            end
                            state_next = ST_TICK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Copy pass: read a row, then write it back with the masked fields
            ST_SWEEP_RD:
            begin
                state_next = ST_SWEEP_WR;
            end

            ST_SWEEP_WR:
            begin
                mctl.we         = 1'b1;
                mctl.wmask      = sweep_mask_reg;
                wdata[F_MEAS]   = rdata[F_MEAS];
                wdata[F_RSTART] = rdata[F_MEAS];
                wdata[F_TPOS]   = rdata[F_MEAS];
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = after_reg;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SWEEP_RD;
                end
            end

            ST_ELEM:
            begin
                waddr          = AW'(joint_reg);
                mctl.we        = jvalid && (elem_mask != '0);
                mctl.wmask     = elem_mask;
                wdata[F_TPOS]  = pos_reg;
                wdata[F_TVEL]  = vel_reg;
                wdata[F_TEFF]  = eff_reg;
                if (last_reg)
                begin
                    cmd_open_next = 1'b0;
                    seen_cmd_next = 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_kind    = KIND_REPORT;
                    ld_eor     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_TICK_RD:
            begin
                state_next = ST_TICK_SEL;
            end

            // Choose the command source for this joint
            ST_TICK_SEL:
            begin
                res_vel_next = '0;
                res_eff_next = '0;
                state_next   = ST_TICK_EMIT;
                case (mode_reg)
                    MODE_DAMP:
                    begin
                        res_pos_next = rdata[F_MEAS];
                    end
                    MODE_CONTROL:
                    begin
                        res_pos_next = rdata[F_TPOS];
                        res_vel_next = rdata[F_TVEL];
                        res_eff_next = rdata[F_TEFF];
                    end
                    default:
                    begin
                        if (ramp_active_reg)
                        begin
                            p1_next    = $signed(rdata[F_RSTART]) * $signed({1'b0, t_minus_e});
                            p2_next    = pose_v * $signed({2'b0, elapsed_reg});
                            state_next = ST_TICK_SUM;
                        end
                        else
                        begin
                            res_pos_next = pose_v;
                        end
                    end
                endcase
            end

            ST_TICK_SUM:
            begin
                div_start  = 1'b1;
                state_next = ST_TICK_DIV;
            end

            // Remove the quotient bias by flipping its top bit
            ST_TICK_DIV:
            begin
                if (div_stat.done)
                begin
                    res_pos_next = {~div_q[VW-1], div_q[VW-2:0]};
                    state_next   = ST_TICK_EMIT;
                end
            end

            ST_TICK_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    ld_kind  = KIND_JOINT;
                    ld_joint = JOINT_W'(idx_reg);
                    ld_pos   = res_pos_reg;
                    ld_vel   = res_vel_reg;
                    ld_eff   = res_eff_reg;
                    ld_eor   = (idx_reg == LAST_IDX);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_TICK_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_START_IN_CONTROL:
                begin
                    start_ctrl_next = cfg_data[0];
                    if (!seen_meas_reg && mode_reg != MODE_DAMP)
                    begin
                        mode_next = cfg_data[0] ? MODE_CONTROL : MODE_NEUTRAL;
                    end
                end
                CFG_RAMP_TICKS:
                begin
                    ramp_ticks_next = cfg_data;
                end
                default:
                begin
                    ramp_ticks_next = ramp_ticks_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            after_reg       <= ST_IDLE;
            idx_reg         <= '0;
            sweep_mask_reg  <= '0;
            mode_reg        <= MODE_NEUTRAL;
            elapsed_reg     <= '0;
            ramp_active_reg <= 1'b0;
            seen_meas_reg   <= 1'b0;
            seen_cmd_reg    <= 1'b0;
            prev_ctrl_reg   <= 1'b0;
            cmd_open_reg    <= 1'b0;
            start_ctrl_reg  <= 1'b0;
            ramp_ticks_reg  <= RAMP_TICKS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            after_reg       <= after_next;
            idx_reg         <= idx_next;
            sweep_mask_reg  <= sweep_mask_next;
            mode_reg        <= mode_next;
            elapsed_reg     <= elapsed_next;
            ramp_active_reg <= ramp_active_next;
            seen_meas_reg   <= seen_meas_next;
            seen_cmd_reg    <= seen_cmd_next;
            prev_ctrl_reg   <= prev_ctrl_next;
            cmd_open_reg    <= cmd_open_next;
            start_ctrl_reg  <= start_ctrl_next;
            ramp_ticks_reg  <= ramp_ticks_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: latch the request, stage products and results, load the output
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= func;
            joint_reg <= joint;
            pos_reg   <= position;
            vel_reg   <= velocity;
            eff_reg   <= effort;
            hp_reg    <= with_position;
            hv_reg    <= with_velocity;
            he_reg    <= with_effort;
            last_reg  <= last;
            damp_reg  <= damp_button;
            ctrl_reg  <= control_button;
        end
        res_pos_reg <= res_pos_next;
        res_vel_reg <= res_vel_next;
        res_eff_reg <= res_eff_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        if (out_load)
        begin
            kind_reg   <= ld_kind;
            ojoint_reg <= ld_joint;
            opos_reg   <= ld_pos;
            ovel_reg   <= ld_vel;
            oeff_reg   <= ld_eff;
            omode_reg  <= mode_reg;
            eor_reg    <= ld_eor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_joint    = ojoint_reg;
    assign out_position = opos_reg;
    assign out_velocity = ovel_reg;
    assign out_effort   = oeff_reg;
    assign mode         = omode_reg;
    assign end_of_run   = eor_reg;

    // Checks
    `JCSS_ASSERT_NOW(a_load_only_when_free, out_load, !out_valid_reg || !out_stall, "output register overwritten while held")
    `JCSS_ASSERT_NEXT(a_damp_latches, mode_reg == MODE_DAMP, mode_reg == MODE_DAMP, "damp mode left before reset")
    `JCSS_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `JCSS_ASSERT_NOW(a_eor_on_last_joint, out_valid && kind == KIND_JOINT && end_of_run, out_joint == JOINT_W'(NUM_JOINTS - 1), "tick run ended on a joint other than the last")

endmodule

// File: design/jcss_mem.sv
// Joint table memory: one row per joint holding measured, ramp start and targets.
// Depends on jcss_pkg; per-field write enables, registered read.
module jcss_mem #(
    parameter int VW = 16,
    parameter int N  = 29,
    parameter int AW = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  jcss_pkg::mem_ctl_t       ctl,
    input  logic [AW-1:0]            waddr,
    input  logic [jcss_pkg::NUM_FIELDS-1:0][VW-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [jcss_pkg::NUM_FIELDS-1:0][VW-1:0] rdata
);
    import jcss_pkg::*;

    logic [NUM_FIELDS-1:0][VW-1:0] ram_reg [N];
    logic [NUM_FIELDS-1:0][VW-1:0] rdata_reg;
    logic [N-1:0]                  valid_reg;
    logic                          rvalid_reg;
    fmask_t                        mask_eff;

    // A row never written reads as zero, so its first write fills every field
    assign mask_eff = valid_reg[waddr] ? ctl.wmask : '1;

    // Track written rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Write enabled fields, register the read row
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                if (mask_eff[k])
                begin
                    ram_reg[waddr][k] <= wdata[k];
                end
            end
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// File: design/jcss_div.sv
// Restoring divider for the neutral ramp, one quotient bit per cycle.
// Depends on jcss_pkg; the quotient must fit in VW bits.
module jcss_div #(
    parameter int VW  = 16,
    parameter int DW  = 33,
    parameter int VSW = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [VSW-1:0]      divisor,
    output jcss_pkg::div_stat_t stat,
    output logic [VW-1:0]       quotient
);
    import jcss_pkg::*;

    localparam int CW = $clog2(VW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [VW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          fits;

    assign fits = (rem_reg >= dvs_reg);

    // Control: step count and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: subtract the shifted divisor where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= DW'(divisor) << (VW - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= {q_reg[VW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// File: dv/tb.sv
// Self-checking testbench for joint_command_safety_supervisor_top.
// Holds its own predictor of modes, joint tables and the neutral ramp, and uses
// only the jcss_pkg constants. Directed tests run first, then random ones, and a damp test ends the run.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jcss_pkg::*;

    localparam int NJ = 29;

    typedef struct {
        logic [1:0]   fn;
        logic [4:0]   jt;
        logic [15:0]  pos, vel, eff;
        logic         hp, hv, he, lst, dmp, ctl;
    } request_t;

    typedef struct {
        logic         knd;
        logic [4:0]   jt;
        logic [15:0]  pos, vel, eff;
        logic [1:0]   md;
        logic         eor;
    } joint_out_t;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_stall;
    logic [1:0] func = 0;
    logic [4:0] joint = 0;
    logic signed [15:0] position = 0, velocity = 0, effort = 0;
    logic with_position = 0, with_velocity = 0, with_effort = 0, last = 0;
    logic damp_button = 0, control_button = 0;
    logic out_valid, out_stall = 0, kind, end_of_run;
    logic [4:0] out_joint;
    logic signed [15:0] out_position, out_velocity, out_effort;
    logic [1:0] mode;
    logic cfg_valid = 0, cfg_ready, cfg_index = 0;
    logic [15:0] cfg_data = 0;

    joint_command_safety_supervisor_top dut (.*);

    always #6 clk = ~clk;

    // Predicted state
    mode_t       p_mode;
    logic        p_start_ctl;
    logic [15:0] p_ramp_ticks, p_elapsed;
    logic signed [15:0] p_meas[NJ], p_rstart[NJ], p_tpos[NJ], p_tvel[NJ], p_teff[NJ];
    logic        p_ramp_on, p_seen_meas, p_seen_cmd, p_prev_ctl, p_msg_open;
    logic signed [15:0] home_pose[NJ] = '{
        -410, 0, 0, 1229, -819, 0, -410, 0, 0, 1229, -819, 0, 0, 0, 0,
        1516, 2540, 0, 3359, 0, 0, 0, 1352, -2744, 0, 4137, 0, 0, 0};

    joint_out_t  pending_outputs[$];
    int          n_errors = 0;
    bit          quiet = 0;
    int          idle_pct = 25;
    int          stall_left = 0;

    // Initialize predictor state to reset values
    initial
    begin
        p_mode = MODE_NEUTRAL; p_start_ctl = 0; p_ramp_ticks = 300; p_elapsed = 0;
        p_ramp_on = 0; p_seen_meas = 0; p_seen_cmd = 0; p_prev_ctl = 0; p_msg_open = 0;
        for (int i = 0; i < NJ; i++)
        begin
            p_meas[i] = 0; p_rstart[i] = 0; p_tpos[i] = 0; p_tvel[i] = 0; p_teff[i] = 0;
        end
    end

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic void push_out(logic knd, int j, logic [15:0] p, logic [15:0] v,
                                     logic [15:0] e, logic eor);
        joint_out_t r;
        r.knd = knd; r.jt = j[4:0]; r.pos = p; r.vel = v; r.eff = e;
        r.md = p_mode; r.eor = eor;
        pending_outputs = {pending_outputs, r};
    endfunction

    function automatic bit change_mode(mode_t m);
        if (m == p_mode)
            return 0;
        p_mode = m;
        return 1;
    endfunction

    function automatic bit begin_ramp();
        for (int i = 0; i < NJ; i++)
            p_rstart[i] = p_meas[i];
        p_elapsed = 0;
        p_ramp_on = 1;
        return change_mode(MODE_NEUTRAL);
    endfunction

    // Advance the predicted state by one accepted request
    function automatic void predict_request(request_t q);
        bit rep;
        bit ok_j;
        longint t, el, num, p;
        rep = 0;
        ok_j = q.jt < NJ;
        case (q.fn)
            FN_JOY:
            begin
                if (q.dmp && p_mode != MODE_DAMP)
                begin
                    p_ramp_on = 0;
                    rep = change_mode(MODE_DAMP);
                end
                else if (p_mode != MODE_DAMP)
                begin
                    if (q.ctl && !p_prev_ctl)
                    begin
                        if (p_mode == MODE_CONTROL)
                            rep = p_seen_meas ? begin_ramp() : change_mode(MODE_NEUTRAL);
                        else if (!p_ramp_on && p_seen_cmd)
                            rep = change_mode(MODE_CONTROL);
                    end
                    p_prev_ctl = q.ctl;
                end
            end
            FN_MEAS:
            begin
                if (ok_j)
                    p_meas[q.jt] = q.pos;
                if (q.lst && !p_seen_meas)
                begin
                    p_seen_meas = 1;
                    for (int i = 0; i < NJ; i++)
                    begin
                        p_tpos[i] = p_meas[i]; p_tvel[i] = 0; p_teff[i] = 0;
                    end
                    if (p_mode == MODE_NEUTRAL)
                        rep = begin_ramp();
                end
            end
            FN_CMD:
            begin
                if (!p_seen_meas)
                    return;
                if (!p_msg_open)
                begin
                    for (int i = 0; i < NJ; i++)
                    begin
                        if (!p_seen_cmd)
                            p_tpos[i] = p_meas[i];
                        p_tvel[i] = 0; p_teff[i] = 0;
                    end
                    p_msg_open = 1;
                end
                if (ok_j)
                begin
                    if (q.hp) p_tpos[q.jt] = q.pos;
                    if (q.hv) p_tvel[q.jt] = q.vel;
                    if (q.he) p_teff[q.jt] = q.eff;
                end
                if (q.lst)
                begin
                    p_msg_open = 0;
                    p_seen_cmd = 1;
                end
            end
            default:
            begin
                if (!p_seen_meas)
                    return;
                if (p_mode == MODE_NEUTRAL && p_ramp_on)
                begin
                    if (p_elapsed != 16'hFFFF)
                        p_elapsed++;
                    if (p_elapsed >= p_ramp_ticks)
                        p_ramp_on = 0;
                end
                for (int i = 0; i < NJ; i++)
                begin
                    if (p_mode == MODE_DAMP)
                        push_out(KIND_JOINT, i, p_meas[i], 0, 0, i == NJ - 1);
                    else if (p_mode == MODE_CONTROL)
                        push_out(KIND_JOINT, i, p_tpos[i], p_tvel[i], p_teff[i], i == NJ - 1);
                    else if (p_ramp_on)
                    begin
                        t = p_ramp_ticks;
                        el = p_elapsed;
                        num = longint'(p_rstart[i]) * (t - el) + longint'(home_pose[i]) * el;
                        p = floor_quot(2 * num + t, 2 * t);
                        push_out(KIND_JOINT, i, p[15:0], 0, 0, i == NJ - 1);
                    end
                    else
                        push_out(KIND_JOINT, i, home_pose[i], 0, 0, i == NJ - 1);
                end
            end
        endcase
        if (rep)
            push_out(KIND_REPORT, 0, 0, 0, 0, 1);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        joint_out_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
                report_mismatch("unexpected result, joint", out_joint, -1);
            else
            begin
                w = pending_outputs.pop_front();
                if (kind !== w.knd) report_mismatch("kind", kind, w.knd);
                if (out_joint !== w.jt) report_mismatch("joint", out_joint, w.jt);
                if (out_position !== w.pos)
                    report_mismatch("position", out_position, $signed(w.pos));
                if (out_velocity !== w.vel)
                    report_mismatch("velocity", out_velocity, $signed(w.vel));
                if (out_effort !== w.eff)
                    report_mismatch("effort", out_effort, $signed(w.eff));
                if (mode !== w.md) report_mismatch("mode", mode, w.md);
                if (end_of_run !== w.eor) report_mismatch("end_of_run", end_of_run, w.eor);
            end
        end
    end

    // Stall the output in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1;
        end
        else if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 13);
            out_stall <= 1;
        end
        else
            out_stall <= 0;
    end

    // Send one request; valid stays high afterwards unless a gap follows
    task automatic send_request(request_t q);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1;
        func <= q.fn; joint <= q.jt; position <= q.pos; velocity <= q.vel; effort <= q.eff;
        with_position <= q.hp; with_velocity <= q.hv; with_effort <= q.he; last <= q.lst;
        damp_button <= q.dmp; control_button <= q.ctl;
        do
            @(posedge clk);
        while (in_stall);
        predict_request(q);
    endtask

    task automatic send_joy(bit dmp, bit ctl);
        request_t q = '{fn: FN_JOY, jt: $urandom, pos: $urandom, vel: $urandom,
                        eff: $urandom, hp: $urandom, hv: $urandom, he: $urandom,
                        lst: $urandom, dmp: dmp, ctl: ctl};
        send_request(q);
    endtask

    task automatic send_meas(int j, logic [15:0] p, bit lst);
        request_t q = '{fn: FN_MEAS, jt: j, pos: p, vel: $urandom, eff: $urandom,
                        hp: $urandom, hv: $urandom, he: $urandom, lst: lst,
                        dmp: $urandom, ctl: $urandom};
        send_request(q);
    endtask

    task automatic send_cmd(int j, logic [15:0] p, logic [15:0] v, logic [15:0] e,
                            bit hp, bit hv, bit he, bit lst);
        request_t q = '{fn: FN_CMD, jt: j, pos: p, vel: v, eff: e, hp: hp, hv: hv,
                        he: he, lst: lst, dmp: $urandom, ctl: $urandom};
        send_request(q);
    endtask

    task automatic send_tick();
        request_t q = '{fn: FN_TICK, jt: $urandom, pos: $urandom, vel: $urandom,
                        eff: $urandom, hp: $urandom, hv: $urandom, he: $urandom,
                        lst: $urandom, dmp: $urandom, ctl: $urandom};
        send_request(q);
    endtask

    // Drain outstanding results, hold for silent work, then write a register
    task automatic write_reg(logic idx, logic [15:0] val);
        in_valid <= 0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == CFG_START_IN_CONTROL)
        begin
            p_start_ctl = val[0];
            if (!p_seen_meas && p_mode != MODE_DAMP)
                p_mode = val[0] ? MODE_CONTROL : MODE_NEUTRAL;
        end
        else
            p_ramp_ticks = val;
    endtask

    // Start mode register, toggling before any measurement, silent items
    task automatic test_config_before_measurement();
        send_tick();
        write_reg(CFG_START_IN_CONTROL, 1);
        send_joy(0, 1);
        send_joy(0, 0);
        send_cmd(2, 100, 200, 300, 1, 1, 1, 1);
        send_joy(0, 1);
        write_reg(CFG_START_IN_CONTROL, 1);
        write_reg(CFG_RAMP_TICKS, 3);
    endtask

    // First measured message in control, then a ramp out of control
    task automatic test_measurement_and_ramp();
        send_meas(0, 16'h7FFF, 0);
        send_meas(31, 1234, 0);
        send_meas(28, 16'h8000, 1);
        send_meas(5, 777, 1);
        write_reg(CFG_START_IN_CONTROL, 0);
        send_tick();
        send_joy(0, 0);
        send_joy(0, 1);
        repeat (4) send_tick();
    endtask

    // Command message then a control edge, zero-length ramp
    task automatic test_command_and_control();
        send_cmd(3, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1, 1, 0);
        send_cmd(30, 5, 5, 5, 1, 1, 1, 0);
        send_cmd(4, 0, 16'h7FFF, 16'h8000, 0, 1, 1, 1);
        send_joy(0, 0);
        send_joy(0, 1);
        send_tick();
        send_cmd(7, 99, 0, 0, 1, 0, 0, 1);
        send_tick();
        write_reg(CFG_RAMP_TICKS, 0);
        send_joy(0, 0);
        send_joy(0, 1);
        send_tick();
        send_tick();
        write_reg(CFG_RAMP_TICKS, 16'hFFFF);
    endtask

    // Random well-formed messages and events, with some noise
    task automatic test_random(int n_items, bit allow_damp);
        int sent;
        int sel, len, j;
        sent = 0;
        while (sent < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 22)
                send_tick();
            else if (sel < 45)
                send_joy(allow_damp && $urandom_range(0, 9) == 0, $urandom);
            else if (sel < 65)
            begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    j = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(0, 28);
                    send_meas(j, $urandom, k == len - 1);
                end
                sent += len - 1;
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                begin
                    j = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(0, 28);
                    send_cmd(j, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             (k == len - 1) || $urandom_range(0, 19) == 0);
                end
                sent += len - 1;
            end
            sent++;
        end
    endtask

    // Damp latches: reports once, holds measured positions, ignores the rest
    task automatic test_damp_latch();
        send_joy(1, 0);
        send_tick();
        send_joy(1, 1);
        send_joy(0, 0);
        send_joy(0, 1);
        write_reg(CFG_START_IN_CONTROL, 0);
        send_meas(1, 16'h8000, 1);
        send_tick();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_config_before_measurement();
        test_measurement_and_ramp();
        test_command_and_control();
        test_random(35, 0);
        write_reg(CFG_RAMP_TICKS, 1);
        write_reg(CFG_START_IN_CONTROL, 1);
        idle_pct = 0;
        test_random(50, 0);
        idle_pct = 40;
        write_reg(CFG_RAMP_TICKS, $urandom_range(2, 6));
        test_random(90, 0);
        write_reg(CFG_RAMP_TICKS, 300);
        quiet = 1;
        test_random(25, 0);
        test_random(25, 1);
        test_damp_latch();
        in_valid <= 0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
